FILE: design/stb_pkg.sv
// ----------------------------------------------------------------------------
// Timer bank package
// Shared constants, operation and status codes, and controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package stb_pkg;

   localparam int NUM_TIMERS = 32;
   localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   localparam int OP_W   = 3;
   localparam int ID_W   = 5;
   localparam int DUR_W  = 31;
   localparam int REM_W  = 32;
   localparam int STAT_W = 2;

   localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
   localparam logic [OP_W-1:0] OP_START  = 3'd1;
   localparam logic [OP_W-1:0] OP_STOP   = 3'd2;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
   localparam logic [OP_W-1:0] OP_TICK   = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
   localparam logic [STAT_W-1:0] ST_NOSLOT = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic accept_ctrl;   // take a create/start/stop/delete/other transaction
      logic accept_tick;   // take a tick transaction, begin the slot scan
      logic scan_step;     // retire the slot under scan and advance
      logic emit_final;    // load the end-of-tick result
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;       // output register can take a result this cycle
      logic slot_expiring;  // slot under scan reports an expiry
      logic scan_last;      // slot under scan is the highest one
   } dp_status_type;

endpackage

FILE: design/stb_req_if.sv
// ----------------------------------------------------------------------------
// Timer bank request channel
// Valid/ready channel carrying one command transaction.
// ----------------------------------------------------------------------------
interface stb_req_if
   import stb_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [ID_W-1:0]   timer_id;
   logic              periodic;
   logic [DUR_W-1:0]  duration;
   logic [DUR_W-1:0]  elapsed;

   modport source (output valid, op, timer_id, periodic, duration, elapsed,
                   input ready);
   modport sink   (input valid, op, timer_id, periodic, duration, elapsed,
                   output ready);
endinterface

FILE: design/stb_rsp_if.sv
// ----------------------------------------------------------------------------
// Timer bank response channel
// Valid/ready channel carrying one result transaction.
// ----------------------------------------------------------------------------
interface stb_rsp_if
   import stb_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [ID_W-1:0]   slot;
   logic [STAT_W-1:0] status;
   logic              expired;
   logic              last;

   modport source (output valid, slot, status, expired, last, input ready);
   modport sink   (input valid, slot, status, expired, last, output ready);
endinterface

FILE: design/stb_ctrl.sv
// ----------------------------------------------------------------------------
// Timer bank controller
// Sequences command transactions and the per-slot tick scan.
// ----------------------------------------------------------------------------
module stb_ctrl
   import stb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [OP_W-1:0] req_op,
   output logic            req_ready,
   input  dp_status_type   status,
   output ctrl_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_FINAL = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE) && status.out_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in         = state_ff;
      cmd              = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_TICK) begin
                  cmd.accept_tick = 1'b1;
                  state_in        = ST_SCAN;
               end else begin
                  cmd.accept_ctrl = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            // hold the slot while its expiry cannot be delivered
            cmd.scan_step = !(status.slot_expiring && !status.out_free);
            if (cmd.scan_step && status.scan_last) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            if (status.out_free) begin
               cmd.emit_final = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: design/stb_datapath.sv
// ----------------------------------------------------------------------------
// Timer bank datapath
// Slot flags, slot memories, scan counter and the result register.
// ----------------------------------------------------------------------------
module stb_datapath
   import stb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  ctrl_cmd_type      cmd,
   output dp_status_type     status,
   input  logic [OP_W-1:0]   req_op,
   input  logic [ID_W-1:0]   req_timer_id,
   input  logic              req_periodic,
   input  logic [DUR_W-1:0]  req_duration,
   input  logic [DUR_W-1:0]  req_elapsed,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [ID_W-1:0]   rsp_slot,
   output logic [STAT_W-1:0] rsp_status,
   output logic              rsp_expired,
   output logic              rsp_last
);

   // per-slot flags; fresh marks a started slot whose remaining time is
   // still the full period
   logic [NUM_TIMERS-1:0] alloc_ff, alloc_in;
   logic [NUM_TIMERS-1:0] run_ff, run_in;
   logic [NUM_TIMERS-1:0] fresh_ff, fresh_in;

   logic              mode_mem   [NUM_TIMERS];
   logic [DUR_W-1:0]  period_mem [NUM_TIMERS];
   logic [REM_W-1:0]  rem_mem    [NUM_TIMERS];
   logic              mode_rd_ff;
   logic [DUR_W-1:0]  period_rd_ff;
   logic [REM_W-1:0]  rem_rd_ff;

   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [DUR_W-1:0]  el_ff;
   logic [IDX_W-1:0]  rd_addr;

   logic              out_valid_ff, out_valid_in;
   logic [ID_W-1:0]   out_slot_ff, out_slot_in;
   logic [STAT_W-1:0] out_status_ff, out_status_in;
   logic              out_expired_ff, out_expired_in;
   logic              out_last_ff, out_last_in;

   logic              free_found;
   logic [IDX_W-1:0]  free_idx;
   logic              id_ok;
   logic [IDX_W-1:0]  id_idx;
   logic              id_alloc;
   logic              active;
   logic [REM_W-1:0]  eff_rem;
   logic              expiring;
   logic              create_wr;
   logic              rem_wr;
   logic [REM_W-1:0]  rem_wr_data;

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
         if (!alloc_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   assign id_ok    = 32'(req_timer_id) < NUM_TIMERS;
   assign id_idx   = IDX_W'(req_timer_id);
   assign id_alloc = id_ok && alloc_ff[id_idx];

   // slot under scan
   assign active   = alloc_ff[idx_ff] && run_ff[idx_ff];
   assign eff_rem  = fresh_ff[idx_ff] ? {1'b0, period_rd_ff} : rem_rd_ff;
   assign expiring = active && eff_rem[REM_W-1];

   assign status.out_free      = !out_valid_ff || rsp_ready;
   assign status.slot_expiring = expiring;
   assign status.scan_last     = idx_ff == IDX_W'(NUM_TIMERS - 1);

   assign create_wr   = cmd.accept_ctrl && (req_op == OP_CREATE) && free_found;
   assign rem_wr      = cmd.scan_step && active && !(expiring && !mode_rd_ff);
   assign rem_wr_data = expiring ? {1'b0, period_rd_ff}
                                 : eff_rem - {1'b0, el_ff};

   // read slot 0 on a tick, re-read on a stall, else prefetch the next
   always_comb begin
      if (cmd.accept_tick) begin
         rd_addr = '0;
      end else if (cmd.scan_step) begin
         rd_addr = idx_ff + 1'b1;
      end else begin
         rd_addr = idx_ff;
      end
   end

   always_comb begin
      alloc_in = alloc_ff;
      run_in   = run_ff;
      fresh_in = fresh_ff;
      idx_in   = idx_ff;
      if (cmd.accept_ctrl) begin
         case (req_op)
            OP_CREATE: begin
               if (free_found) begin
                  alloc_in[free_idx] = 1'b1;
                  run_in[free_idx]   = 1'b0;
               end
            end
            OP_START: begin
               if (id_alloc) begin
                  run_in[id_idx]   = 1'b1;
                  fresh_in[id_idx] = 1'b1;
               end
            end
            OP_STOP: begin
               if (id_alloc) begin
                  run_in[id_idx] = 1'b0;
               end
            end
            OP_DELETE: begin
               if (id_alloc) begin
                  alloc_in[id_idx] = 1'b0;
                  run_in[id_idx]   = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
      if (cmd.accept_tick) begin
         idx_in = '0;
      end
      if (cmd.scan_step) begin
         idx_in = idx_ff + 1'b1;
         if (active) begin
            fresh_in[idx_ff] = 1'b0;
            if (expiring && !mode_rd_ff) begin
               run_in[idx_ff] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      out_valid_in   = out_valid_ff;
      out_slot_in    = out_slot_ff;
      out_status_in  = out_status_ff;
      out_expired_in = out_expired_ff;
      out_last_in    = out_last_ff;
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.accept_ctrl) begin
         out_valid_in   = 1'b1;
         out_expired_in = 1'b0;
         out_last_in    = 1'b1;
         case (req_op)
            OP_CREATE: begin
               out_slot_in   = free_found ? ID_W'(free_idx) : '0;
               out_status_in = free_found ? ST_OK : ST_EMPTY;
            end
            OP_START, OP_STOP, OP_DELETE: begin
               out_slot_in   = req_timer_id;
               out_status_in = id_alloc ? ST_OK : ST_NOSLOT;
            end
            default: begin
               out_slot_in   = '0;
               out_status_in = ST_OK;
            end
         endcase
      end else if (cmd.scan_step && expiring) begin
         out_valid_in   = 1'b1;
         out_slot_in    = ID_W'(idx_ff);
         out_status_in  = ST_OK;
         out_expired_in = 1'b1;
         out_last_in    = 1'b0;
      end else if (cmd.emit_final) begin
         out_valid_in   = 1'b1;
         out_slot_in    = '0;
         out_status_in  = ST_OK;
         out_expired_in = 1'b0;
         out_last_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_ff     <= '0;
         run_ff       <= '0;
         fresh_ff     <= '0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         alloc_ff     <= alloc_in;
         run_ff       <= run_in;
         fresh_ff     <= fresh_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_slot_ff    <= out_slot_in;
      out_status_ff  <= out_status_in;
      out_expired_ff <= out_expired_in;
      out_last_ff    <= out_last_in;
      if (cmd.accept_tick) begin
         el_ff <= req_elapsed;
      end
   end

   // mode and period memories: written on create
   always_ff @(posedge clock) begin
      if (create_wr) begin
         mode_mem[free_idx]   <= req_periodic;
         period_mem[free_idx] <= req_duration;
      end
      mode_rd_ff   <= mode_mem[rd_addr];
      period_rd_ff <= period_mem[rd_addr];
   end

   // remaining-time memory: written during the scan
   always_ff @(posedge clock) begin
      if (rem_wr) begin
         rem_mem[idx_ff] <= rem_wr_data;
      end
      rem_rd_ff <= rem_mem[rd_addr];
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_slot    = out_slot_ff;
   assign rsp_status  = out_status_ff;
   assign rsp_expired = out_expired_ff;
   assign rsp_last    = out_last_ff;

endmodule

FILE: design/software_timer_bank_unit.sv
// ----------------------------------------------------------------------------
// Software timer bank unit
// Bank of one-shot and periodic timer slots driven by command transactions.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one command transaction: create, start, stop, delete or
//   tick. rsp_ch returns the results; the final result of every command has
//   last set.
//   Create, start, stop, delete and unused codes give one result, registered
//   on the cycle after acceptance.
//   A tick scans every slot through the slot memories, one slot a cycle
//   unless the receiver stalls on an expiring slot. The tick is accepted,
//   each slot is scanned in turn, then the end-of-tick result is loaded.
//   Each expiring slot adds one result before the final one. The next
//   command is taken only once the tick is done.
//   The result register is freed in the cycle the receiver takes it, so a
//   new command is accepted while a result is being handed over.
//   If the receiver stalls, the scan holds on an expiring slot and no new
//   command is accepted while the result register is full.
//   Reset frees every slot and empties the result register; mode, period
//   and remaining-time memories need no clearing.
// ----------------------------------------------------------------------------
module software_timer_bank_unit
   import stb_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   stb_req_if.sink   req_ch,
   stb_rsp_if.source rsp_ch
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequencing: accepts transactions and steps the tick scan
   stb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_op    (req_ch.op),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // slot state, memories and the result register
   stb_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_op       (req_ch.op),
      .req_timer_id (req_ch.timer_id),
      .req_periodic (req_ch.periodic),
      .req_duration (req_ch.duration),
      .req_elapsed  (req_ch.elapsed),
      .rsp_valid    (rsp_ch.valid),
      .rsp_ready    (rsp_ch.ready),
      .rsp_slot     (rsp_ch.slot),
      .rsp_status   (rsp_ch.status),
      .rsp_expired  (rsp_ch.expired),
      .rsp_last     (rsp_ch.last)
   );

endmodule
